>>> sv/io_fr_pkg.sv
package io_fr_pkg;

    localparam logic [1:0] MODE_REQUEST = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_SWITCH  = 2'd2;
    localparam logic [1:0] MODE_FORCE   = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [4:0] job_id;
    } t_fr_in;

    typedef struct packed {
        logic        focus_valid;
        logic [4:0]  focus_job;
        logic        focus_changed;
        logic        step_status;
        logic [31:0] member_map;
    } t_fr_out;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_REQ,
        OP_REL,
        OP_SW,
        OP_FORCE
    } t_fr_op;

    typedef struct packed {
        t_fr_op     op;
        logic [4:0] job;
    } t_fr_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RD,
        ST_WR,
        ST_DONE
    } t_fr_state;

endpackage

>>> sv/io_focus_ring_unit.sv
// Path: a pushed word waits in the front queue; the back sequencer takes it
// in IDLE, then passes EVAL, RD (registered reads of the next/prev link
// memories) for a switch of a non-empty ring, a release of a member or an
// insert into a non-empty ring, WR for that insert, and DONE, which
// registers the result; the back takes no new word until it is through DONE.
// Reset: synchronous, active low; ring, focus and queues cleared, links
// left as they are.
module io_focus_ring_unit #(
    parameter int MAX_JOBS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  io_fr_pkg::t_fr_in  i_item,
    output logic               empty,
    input  logic               pop,
    output io_fr_pkg::t_fr_out o_result
);
    import io_fr_pkg::*;

    t_fr_cmd cmd;
    logic    cmd_valid;
    logic    cmd_take;
    logic    res_valid;
    logic    res_take;

    assign empty    = !res_valid;
    assign res_take = pop && res_valid;

    io_fr_front #(
        .MAX_JOBS(MAX_JOBS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .o_cmd      (cmd),
        .o_cmd_valid(cmd_valid),
        .i_cmd_take (cmd_take)
    );

    io_fr_back #(
        .MAX_JOBS(MAX_JOBS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cmd_valid(cmd_valid),
        .o_cmd_take (cmd_take),
        .o_res      (o_result),
        .o_res_valid(res_valid),
        .i_res_take (res_take)
    );

    a_no_focus_zero_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.focus_valid) |-> (o_result.focus_job == 5'd0))
        else $error("focus_job nonzero without focus");

    a_holder_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.focus_valid) |-> o_result.member_map[o_result.focus_job])
        else $error("focus holder not in ring");

    a_empty_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_result.member_map == 32'd0) == !o_result.focus_valid))
        else $error("focus state disagrees with ring membership");

    a_change_acts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.focus_changed) |-> !o_result.step_status)
        else $error("focus change flagged on a step with no effect");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule

>>> sv/io_fr_front.sv
module io_fr_front #(
    parameter int MAX_JOBS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  io_fr_pkg::t_fr_in  i_item,
    output io_fr_pkg::t_fr_cmd o_cmd,
    output logic               o_cmd_valid,
    input  logic               i_cmd_take
);
    import io_fr_pkg::*;

    t_fr_cmd    r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_fr_cmd    cls;
    logic       in_range;
    logic       do_push;
    logic       do_pop;

    always_comb begin
        in_range = 32'(i_item.job_id) < 32'(MAX_JOBS);
        cls.job  = i_item.job_id;
        case (i_item.mode)
            MODE_REQUEST: cls.op = in_range ? OP_REQ : OP_NOP;
            MODE_RELEASE: cls.op = in_range ? OP_REL : OP_NOP;
            MODE_SWITCH:  cls.op = OP_SW;
            MODE_FORCE:   cls.op = in_range ? OP_FORCE : OP_NOP;
            default:      cls.op = OP_NOP;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

>>> sv/io_fr_back.sv
module io_fr_back #(
    parameter int MAX_JOBS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  io_fr_pkg::t_fr_cmd i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    output io_fr_pkg::t_fr_out o_res,
    output logic               o_res_valid,
    input  logic               i_res_take
);
    import io_fr_pkg::*;

    localparam int LW = $clog2(MAX_JOBS);

    logic [LW-1:0] next_mem [MAX_JOBS];
    logic [LW-1:0] prev_mem [MAX_JOBS];

    t_fr_state     r_state, n_state;
    t_fr_op        r_op, n_op;
    logic [LW-1:0] r_job, n_job;
    logic [MAX_JOBS-1:0] r_member, n_member;
    logic          r_present, n_present;
    logic [LW-1:0] r_holder, n_holder;
    logic [LW-1:0] r_p, n_p;
    logic          r_changed, n_changed;
    logic          r_acted, n_acted;
    t_fr_out       r_res, n_res;
    logic          r_res_full, n_res_full;
    logic [LW-1:0] r_next_rd;
    logic [LW-1:0] r_prev_rd;

    logic          rd_en;
    logic [LW-1:0] next_ra, prev_ra;
    logic          next_we, prev_we;
    logic [LW-1:0] next_wa, next_wd, prev_wa, prev_wd;
    logic          need_rd;
    logic          is_ins;
    logic          res_free;

    assign is_ins   = (r_op == OP_REQ) || (r_op == OP_FORCE);
    assign res_free = !r_res_full || i_res_take;
    assign need_rd  = (is_ins && !r_member[r_job] && r_present)
                   || ((r_op == OP_REL) && r_member[r_job])
                   || ((r_op == OP_SW) && r_present);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_cmd_valid) n_state = ST_EVAL;
            ST_EVAL: n_state = need_rd ? ST_RD : ST_DONE;
            ST_RD:   n_state = is_ins ? ST_WR : ST_DONE;
            ST_WR:   n_state = ST_DONE;
            ST_DONE: if (res_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_op       = r_op;
        n_job      = r_job;
        n_member   = r_member;
        n_present  = r_present;
        n_holder   = r_holder;
        n_p        = r_p;
        n_changed  = r_changed;
        n_acted    = r_acted;
        n_res      = r_res;
        n_res_full = r_res_full;
        o_cmd_take = 1'b0;
        rd_en      = 1'b0;
        next_ra    = (r_op == OP_SW) ? r_holder : r_job;
        prev_ra    = (r_op == OP_REL) ? r_job : r_holder;
        next_we    = 1'b0;
        next_wa    = r_job;
        next_wd    = r_job;
        prev_we    = 1'b0;
        prev_wa    = r_job;
        prev_wd    = r_job;
        if (i_res_take) begin
            n_res_full = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_take = 1'b1;
                    n_op       = i_cmd.op;
                    n_job      = LW'(i_cmd.job);
                    n_changed  = 1'b0;
                    n_acted    = 1'b0;
                end
            end
            ST_EVAL: begin
                rd_en = need_rd;
                if (is_ins) begin
                    if (r_member[r_job]) begin
                        if ((r_op == OP_FORCE) && (r_holder != r_job)) begin
                            n_holder  = r_job;
                            n_changed = 1'b1;
                            n_acted   = 1'b1;
                        end
                    end else if (!r_present) begin
                        // empty ring: job links to itself
                        next_we         = 1'b1;
                        prev_we         = 1'b1;
                        n_member[r_job] = 1'b1;
                        n_present       = 1'b1;
                        n_holder        = r_job;
                        n_acted         = 1'b1;
                    end
                end
            end
            ST_RD: begin
                case (r_op)
                    OP_REQ, OP_FORCE: begin
                        prev_we = 1'b1;
                        prev_wd = r_prev_rd;
                        next_we = 1'b1;
                        next_wd = r_holder;
                        n_p     = r_prev_rd;
                    end
                    OP_REL: begin
                        n_member[r_job] = 1'b0;
                        n_acted         = 1'b1;
                        if (r_next_rd == r_job) begin
                            n_present = 1'b0;
                            n_holder  = '0;
                        end else begin
                            if (r_present && (r_holder == r_job)) begin
                                n_holder  = r_next_rd;
                                n_changed = 1'b1;
                            end
                            prev_we = 1'b1;
                            prev_wa = r_next_rd;
                            prev_wd = r_prev_rd;
                            next_we = 1'b1;
                            next_wa = r_prev_rd;
                            next_wd = r_next_rd;
                        end
                    end
                    OP_SW: begin
                        if (r_next_rd != r_holder) begin
                            n_holder  = r_next_rd;
                            n_changed = 1'b1;
                            n_acted   = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_WR: begin
                next_we         = 1'b1;
                next_wa         = r_p;
                next_wd         = r_job;
                prev_we         = 1'b1;
                prev_wa         = r_holder;
                prev_wd         = r_job;
                n_member[r_job] = 1'b1;
                n_acted         = 1'b1;
                if (r_op == OP_FORCE) begin
                    n_holder  = r_job;
                    n_changed = 1'b1;
                end
            end
            ST_DONE: begin
                if (res_free) begin
                    n_res_full          = 1'b1;
                    n_res.focus_valid   = r_present;
                    n_res.focus_job     = r_present ? 5'(r_holder) : 5'd0;
                    n_res.focus_changed = r_changed;
                    n_res.step_status   = !r_acted;
                    n_res.member_map    = 32'(r_member);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_op       <= OP_NOP;
            r_member   <= '0;
            r_present  <= 1'b0;
            r_holder   <= '0;
            r_res_full <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_member   <= n_member;
            r_present  <= n_present;
            r_holder   <= n_holder;
            r_res_full <= n_res_full;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_p       <= n_p;
        r_changed <= n_changed;
        r_acted   <= n_acted;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (rd_en) begin
            r_next_rd <= next_mem[next_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (rd_en) begin
            r_prev_rd <= prev_mem[prev_ra];
        end
    end

    assign o_res       = r_res;
    assign o_res_valid = r_res_full;

endmodule
